[src/ordered_list_with_positional_delete_defines.svh]
// Assertion macros used by the checker file olpd_checker.sv.
`ifndef ORDERED_LIST_WITH_POSITIONAL_DELETE_DEFINES_SVH
`define ORDERED_LIST_WITH_POSITIONAL_DELETE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define OLPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olpd check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define OLPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olpd check failed");

`endif

[src/olpd_pkg.sv]
package olpd_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int CAPACITY_MAX = 256;
   localparam int IDX_W        = 8;          // index bits for CAPACITY_MAX entries
   localparam int CNT_W        = IDX_W + 1;  // count bits, holds CAPACITY_MAX
   localparam int DATA_W       = 32;
   localparam int POS_W        = 5;
   localparam int LEN_W        = 5;

   typedef enum logic [1:0] {
      FN_APPEND    = 2'd0,
      FN_DEL_FIRST = 2'd1,
      FN_DEL_LAST  = 2'd2,
      FN_DEL_POS   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                     shift;       // take neighbor's value
      logic [IDX_W-1:0]         shift_from;  // cells at or above this index shift
      logic                     write;       // load value
      logic [IDX_W-1:0]         write_at;    // cell that loads value
      logic [IDX_W-1:0]         tail_at;     // cell holding the new tail
      logic signed [DATA_W-1:0] value;
   } cell_op_type;

endpackage

[src/olpd_if.sv]
interface olpd_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic signed [olpd_pkg::DATA_W-1:0] value;
   logic [olpd_pkg::POS_W-1:0]        position;

   modport source (output valid, func, value, position, input ready);
   modport sink   (input valid, func, value, position, output ready);
endinterface

interface olpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic [olpd_pkg::LEN_W-1:0]        length;
   logic signed [olpd_pkg::DATA_W-1:0] first_value;
   logic signed [olpd_pkg::DATA_W-1:0] last_value;

   modport source (output valid, status, length, first_value, last_value, input ready);
   modport sink   (input valid, status, length, first_value, last_value, output ready);
endinterface

[src/olpd_cell.sv]
module olpd_cell #(
   parameter int IDX = 0
) (
   input  logic                               clock,
   input  olpd_pkg::cell_op_type              op,
   input  logic signed [olpd_pkg::DATA_W-1:0] nbr,   // value of the next cell up
   output logic signed [olpd_pkg::DATA_W-1:0] data,
   output logic signed [olpd_pkg::DATA_W-1:0] data_next,
   output logic signed [olpd_pkg::DATA_W-1:0] tap    // next value if this is the tail
);

   localparam logic [olpd_pkg::IDX_W-1:0] IDX_V = olpd_pkg::IDX_W'(IDX);

   logic signed [olpd_pkg::DATA_W-1:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (op.write && (op.write_at == IDX_V)) begin
         data_in = op.value;
      end else if (op.shift && (IDX_V >= op.shift_from)) begin
         data_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign data_next = data_in;
   assign tap       = (op.tail_at == IDX_V) ? data_in : '0;

endmodule

[src/ordered_list_with_positional_delete.sv]
// Ordered list of up to CAPACITY signed 32-bit values with append at the tail
// and delete of the first, the last or the entry at a 1-based position.
// req_bus (sink): one transaction per operation, fields func, value, position.
// rsp_bus (source): one transaction per request with status, length after
//   the operation, and the values now at head and tail (zero when empty).
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle; every cell updates in the same cycle,
//   the cost is three index compares per cell (write, shift and tail) and the tail select across the row.
// The response sits in an output register; a new request is taken when that
//   register is empty or is being drained in the same cycle, so a stalled
//   receiver holds the response and backpressures req_bus after one transaction.
// Reset (synchronous, active high) empties the list and drops any pending
//   response. Cell contents are not cleared; only cells below the count are
//   ever shown.
module ordered_list_with_positional_delete #(
   parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   olpd_req_if.sink   req_bus,
   olpd_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [olpd_pkg::CNT_W-1:0] CAP_V = olpd_pkg::CNT_W'(CAPACITY);

   // list length
   logic [CW-1:0] count_ff, count_in;

   // response register
   logic                               rsp_valid_ff;
   olpd_pkg::status_type               status_ff, status_in;
   logic [olpd_pkg::LEN_W-1:0]         length_ff;
   logic signed [olpd_pkg::DATA_W-1:0] first_ff, first_in;
   logic signed [olpd_pkg::DATA_W-1:0] last_ff, last_in;

   logic                        accept;
   olpd_pkg::func_type          func;
   logic [olpd_pkg::CNT_W-1:0]  cnt_w, cnt_new, pos_w;
   olpd_pkg::cell_op_type       op_raw, op;

   // cell row
   logic signed [olpd_pkg::DATA_W-1:0] cell_q   [CAPACITY];
   logic signed [olpd_pkg::DATA_W-1:0] cell_nxt [CAPACITY];
   logic signed [olpd_pkg::DATA_W-1:0] cell_tap [CAPACITY];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign func          = olpd_pkg::func_type'(req_bus.func);
   assign cnt_w         = olpd_pkg::CNT_W'(count_ff);
   assign pos_w         = olpd_pkg::CNT_W'(req_bus.position);

   // Decode the operation into status, new length and the cell command.
   always_comb begin
      status_in         = olpd_pkg::ST_OK;
      cnt_new           = cnt_w;
      op_raw            = '0;
      op_raw.value      = req_bus.value;
      op_raw.write_at   = olpd_pkg::IDX_W'(cnt_w);
      case (func)
         olpd_pkg::FN_APPEND: begin
            if (cnt_w >= CAP_V) begin
               status_in = olpd_pkg::ST_FULL;
            end else begin
               op_raw.write = 1'b1;
               cnt_new      = cnt_w + 1'b1;
            end
         end
         olpd_pkg::FN_DEL_FIRST: begin
            if (cnt_w == '0) begin
               status_in = olpd_pkg::ST_EMPTY;
            end else begin
               op_raw.shift = 1'b1;
               cnt_new      = cnt_w - 1'b1;
            end
         end
         olpd_pkg::FN_DEL_LAST: begin
            if (cnt_w == '0) begin
               status_in = olpd_pkg::ST_EMPTY;
            end else begin
               cnt_new = cnt_w - 1'b1;
            end
         end
         olpd_pkg::FN_DEL_POS: begin
            if (cnt_w == '0) begin
               status_in = olpd_pkg::ST_EMPTY;
            end else if ((pos_w == '0) || (pos_w > cnt_w)) begin
               status_in = olpd_pkg::ST_BADPOS;
            end else begin
               // later entries move down by one to close the gap
               op_raw.shift      = 1'b1;
               op_raw.shift_from = olpd_pkg::IDX_W'(pos_w - 1'b1);
               cnt_new           = cnt_w - 1'b1;
            end
         end
         default: begin
            status_in = olpd_pkg::ST_OK;
         end
      endcase
      op_raw.tail_at = olpd_pkg::IDX_W'(cnt_new - 1'b1);
   end

   // Cells only move on an accepted transaction.
   always_comb begin
      op       = op_raw;
      op.shift = op_raw.shift && accept;
      op.write = op_raw.write && accept;
   end

   assign count_in = accept ? CW'(cnt_new) : count_ff;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [olpd_pkg::DATA_W-1:0] nbr;
         if (g == CAPACITY - 1) begin : g_top
            assign nbr = cell_q[g];   // topmost cell has no upper neighbor
         end else begin : g_mid
            assign nbr = cell_q[g+1];
         end
         olpd_cell #(.IDX(g)) u_cell (
            .clock     (clock),
            .op        (op),
            .nbr       (nbr),
            .data      (cell_q[g]),
            .data_next (cell_nxt[g]),
            .tap       (cell_tap[g])
         );
      end
   endgenerate

   // Head is always cell 0; tail is picked by the one cell that matches.
   always_comb begin
      last_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         last_in = last_in | cell_tap[i];
      end
      first_in = cell_nxt[0];
      if (cnt_new == '0) begin
         first_in = '0;
         last_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         length_ff <= olpd_pkg::LEN_W'(cnt_new);
         first_ff  <= first_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.length      = length_ff;
   assign rsp_bus.first_value = first_ff;
   assign rsp_bus.last_value  = last_ff;

endmodule

[src/olpd_checker.sv]
`include "ordered_list_with_positional_delete_defines.svh"

module olpd_checker #(
   parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic [olpd_pkg::LEN_W-1:0]         rsp_length,
   input logic signed [olpd_pkg::DATA_W-1:0] rsp_first_value,
   input logic signed [olpd_pkg::DATA_W-1:0] rsp_last_value
);

   localparam logic [olpd_pkg::LEN_W-1:0] CAP_LEN = olpd_pkg::LEN_W'(CAPACITY);

   // stalled response holds valid, status, length and tail value
   `OLPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_length) && $stable(rsp_last_value))

   // full report means the list is at capacity
   `OLPD_ASSERT_NOW(a_full_len, clock, reset, rsp_valid && (rsp_status == olpd_pkg::ST_FULL), rsp_length == CAP_LEN)

   // empty report means zero length and nothing at head or tail
   `OLPD_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && (rsp_status == olpd_pkg::ST_EMPTY), (rsp_length == '0) && (rsp_first_value == '0) && (rsp_last_value == '0))

   // single entry is both head and tail
   `OLPD_ASSERT_NOW(a_single, clock, reset, rsp_valid && (rsp_length == 5'd1), rsp_first_value == rsp_last_value)

endmodule

bind ordered_list_with_positional_delete olpd_checker #(.CAPACITY(CAPACITY)) u_olpd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_length      (rsp_bus.length),
   .rsp_first_value (rsp_bus.first_value),
   .rsp_last_value  (rsp_bus.last_value)
);

[tb/sv/olpd_list_checker.sv]
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow copy of the list and checks every
// response against the next predicted outcome.
module olpd_list_checker #(
   parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   olpd_req_if  req_bus,
   olpd_rsp_if  rsp_bus,
   output int   fail_count,
   output int   outstanding
);
   import olpd_pkg::*;

   typedef struct {
      status_type               status;
      logic [LEN_W-1:0]         length;
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] last_value;
   } list_view_type;

   logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
   int                       shadow_len;
   list_view_type            expected_views [$];

   // Applies one operation to the shadow list, returns the view it leaves.
   function automatic list_view_type apply_list_op(func_type fn,
                                                   logic signed [DATA_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
      list_view_type view;
      int            drop;
      drop = -1;
      view.status = ST_OK;
      if (fn == FN_APPEND) begin
         if (shadow_len >= CAPACITY) begin
            view.status = ST_FULL;
         end else begin
            shadow_vals[shadow_len] = val;
            shadow_len++;
         end
      end else if (shadow_len == 0) begin
         view.status = ST_EMPTY;
      end else if (fn == FN_DEL_FIRST) begin
         drop = 0;
      end else if (fn == FN_DEL_LAST) begin
         drop = shadow_len - 1;
      end else if (pos == 0 || pos > shadow_len) begin
         view.status = ST_BADPOS;
      end else begin
         drop = pos - 1;
      end
      if (drop >= 0) begin
         for (int i = drop; i < shadow_len - 1; i++)
            shadow_vals[i] = shadow_vals[i + 1];
         shadow_len--;
      end
      view.length = shadow_len[LEN_W-1:0];
      view.first_value = (shadow_len == 0) ? '0 : shadow_vals[0];
      view.last_value  = (shadow_len == 0) ? '0 : shadow_vals[shadow_len - 1];
      return view;
   endfunction

   always @(posedge clock) begin
      list_view_type want;
      if (reset) begin
         shadow_len = 0;
         expected_views.delete();
         fail_count = 0;
         outstanding <= 0;
      end else begin
         // response first: it can only belong to an earlier request
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_views.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with nothing pending: status %0d length %0d",
                           $realtime, rsp_bus.status, rsp_bus.length);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.length !== want.length ||
                   rsp_bus.first_value !== want.first_value ||
                   rsp_bus.last_value !== want.last_value) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp/act: status %0d/%0d length %0d/%0d ",
                              $realtime,
                              want.status, rsp_bus.status, want.length, rsp_bus.length,
                              "first %0d/%0d last %0d/%0d",
                              want.first_value, rsp_bus.first_value,
                              want.last_value, rsp_bus.last_value);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_views.push_back(apply_list_op(func_type'(req_bus.func), req_bus.value,
                                                   req_bus.position));
         outstanding <= expected_views.size();
      end
   end

endmodule

[tb/sv/tb_ordered_list_with_positional_delete.sv]
`timescale 1ns / 100ps

module tb_ordered_list_with_positional_delete;
   import olpd_pkg::*;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_OPS = 1525;

   logic clock;
   logic reset;
   int   fail_total;
   int   pending_ops;
   bit   quiet;        // no idle cycles on either side while set
   int   fill_guess;   // rough list length, only steers position choice

   olpd_req_if req_ch ();
   olpd_rsp_if rsp_ch ();

   ordered_list_with_positional_delete uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // predicts and compares; hands back the failure and pending counts
   olpd_list_checker list_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .fail_count  (fail_total),
      .outstanding (pending_ops)
   );

   // 10 ns clock, first rising edge at 5 ns
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One transaction on the request channel. Valid stays high between
   // back-to-back transactions; it only drops when a gap is chosen.
   task automatic issue_op(func_type fn, logic signed [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= fn;
      req_ch.value    <= val;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      // keep a rough length so most positional deletes land inside the list
      case (fn)
         FN_APPEND:    if (fill_guess < CAPACITY_DEF) fill_guess++;
         FN_DEL_FIRST,
         FN_DEL_LAST:  if (fill_guess > 0) fill_guess--;
         default:      if (pos >= 1 && pos <= fill_guess) fill_guess--;
      endcase
   endtask

   // Wait on the handshake until the checker has nothing pending. The count
   // is registered, so look only after an edge has passed.
   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (pending_ops != 0);
   endtask

   // Response side: bursts of ready with random stalls in between.
   initial begin
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      func_type                 fn;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      int                       grow_pct;
      int                       roll;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.func     <= FN_APPEND;
      req_ch.value    <= '0;
      req_ch.position <= '0;
      quiet      = 1'b0;
      fill_guess = 0;
      grow_pct   = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every delete on an empty list
      issue_op(FN_DEL_FIRST, VAL_MAX, 5'd1);
      issue_op(FN_DEL_LAST, VAL_MIN, 5'd1);
      issue_op(FN_DEL_POS, '0, 5'd0);
      // fill to capacity, extreme values first
      for (int i = 0; i < CAPACITY_DEF; i++) begin
         case (i)
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = '0;
            3:       val = -1;
            4:       val = 32'sh5555_5555;
            5:       val = 32'shAAAA_AAAA;
            default: val = $urandom;
         endcase
         issue_op(FN_APPEND, val, 5'd31);
      end
      // append to a full list is dropped
      issue_op(FN_APPEND, 32'sh1234_5678, '0);
      // positions outside the list, top of the field included
      issue_op(FN_DEL_POS, '0, 5'd0);
      issue_op(FN_DEL_POS, '0, 5'd17);
      issue_op(FN_DEL_POS, '0, 5'd31);
      // positional delete of the tail, then the head
      issue_op(FN_DEL_POS, '0, 5'd16);
      issue_op(FN_DEL_POS, '0, 5'd1);
      issue_op(FN_DEL_FIRST, '0, '0);
      issue_op(FN_DEL_LAST, '0, '0);

      // Random: phases that grow, hover or shrink the list
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       grow_pct = 75;
               1:       grow_pct = 50;
               default: grow_pct = 30;
            endcase
         end
         quiet = (n >= 700 && n < 900);
         // hold off until the list has answered everything
         if (n == 400 || n == 1100) begin
            req_ch.valid <= 1'b0;
            wait_until_drained();
         end

         roll = $urandom_range(0, 99);
         if (roll < grow_pct) begin
            fn = FN_APPEND;
         end else begin
            case ($urandom_range(0, 2))
               0:       fn = FN_DEL_FIRST;
               1:       fn = FN_DEL_LAST;
               default: fn = FN_DEL_POS;
            endcase
         end

         roll = $urandom_range(0, 99);
         if (roll < 80)
            pos = (fill_guess > 0) ? POS_W'($urandom_range(1, fill_guess))
                                   : POS_W'($urandom_range(1, 16));
         else if (roll < 90)
            pos = '0;
         else
            pos = POS_W'($urandom_range(fill_guess + 1, 31));

         case ($urandom_range(0, 19))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = '0;
            3:       val = -1;
            default: val = $urandom;
         endcase

         issue_op(fn, val, pos);
      end

      req_ch.valid <= 1'b0;
      wait_until_drained();
      // keep watching so that a stray extra response would still show up
      repeat (4) @(posedge clock);
      if (fail_total == 0 && pending_ops == 0)
         $display("ordered_list_with_positional_delete test passed");
      else
         $display("ordered_list_with_positional_delete test failed");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("ordered_list_with_positional_delete test failed");
      $finish;
   end

endmodule
